// ----- hw/rtl/rbs_pkg.sv -----
// ---------------------------------------------------------------------------
// rbs_pkg
// Widths and constants shared by the 2-D slab intersection block.
// ---------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  // coordinate, delta and slab fraction widths
  localparam int COORD_W = 32;
  localparam int DELTA_W = COORD_W + 1;
  localparam int T_W     = 32;
  localparam int FRAC_W  = 17;
  localparam int NORM_W  = 2;

  // divider: one prep stage, one stage per quotient bit, one saturation stage
  localparam int DIV_LAT = T_W + 2;

  // saturation limits of a slab fraction
  localparam logic signed [T_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [T_W-1:0] T_MIN = 32'sh8000_0000;

  // normal component codes
  localparam logic signed [NORM_W-1:0] NORM_POS  = 2'sb01;
  localparam logic signed [NORM_W-1:0] NORM_NEG  = 2'sb11;
  localparam logic signed [NORM_W-1:0] NORM_ZERO = 2'sb00;

endpackage

`default_nettype wire

// ----- hw/rtl/rbs_req_if.sv -----
// ---------------------------------------------------------------------------
// rbs_req_if
// Request channel: box corners and segment end points, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface rbs_req_if;
  logic valid;
  logic ready;
  logic signed [rbs_pkg::COORD_W-1:0] box_lower_x;
  logic signed [rbs_pkg::COORD_W-1:0] box_lower_y;
  logic signed [rbs_pkg::COORD_W-1:0] box_upper_x;
  logic signed [rbs_pkg::COORD_W-1:0] box_upper_y;
  logic signed [rbs_pkg::COORD_W-1:0] start_x;
  logic signed [rbs_pkg::COORD_W-1:0] start_y;
  logic signed [rbs_pkg::COORD_W-1:0] end_x;
  logic signed [rbs_pkg::COORD_W-1:0] end_y;

  modport source (
    output valid, box_lower_x, box_lower_y, box_upper_x, box_upper_y,
    output start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, box_lower_x, box_lower_y, box_upper_x, box_upper_y,
    input  start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rbs_rsp_if.sv -----
// ---------------------------------------------------------------------------
// rbs_rsp_if
// Result channel: hit flag, entry fraction, normal and point, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface rbs_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rbs_pkg::FRAC_W-1:0] fraction;
  logic signed [rbs_pkg::NORM_W-1:0] normal_x;
  logic signed [rbs_pkg::NORM_W-1:0] normal_y;
  logic signed [rbs_pkg::COORD_W-1:0] point_x;
  logic signed [rbs_pkg::COORD_W-1:0] point_y;

  modport source (
    output valid, hit, fraction, normal_x, normal_y, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, hit, fraction, normal_x, normal_y, point_x, point_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rbs_slab_div.sv -----
// ---------------------------------------------------------------------------
// rbs_slab_div
// Pipelined signed divide (num * 2^FRAC_BITS) / den, truncated toward zero
// and saturated to 32 bits. One quotient bit per stage, enables per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rbs_slab_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic [rbs_pkg::DIV_LAT-1:0]         en,
  input  wire logic signed [rbs_pkg::DELTA_W-1:0]  num,
  input  wire logic signed [rbs_pkg::DELTA_W-1:0]  den,
  output logic signed [rbs_pkg::T_W-1:0]           t
);

  localparam int DW = rbs_pkg::DELTA_W;
  localparam int QW = rbs_pkg::T_W;
  localparam int NW = DW + FRAC_BITS;

  // magnitudes and scaled numerator
  logic [DW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic [NW-1:0] n_scaled;
  logic [DW-1:0] n_top;

  assign num_mag  = num[DW-1] ? DW'(-num) : DW'(num);
  assign den_mag  = den[DW-1] ? DW'(-den) : DW'(den);
  assign n_scaled = NW'(num_mag) << FRAC_BITS;
  assign n_top    = DW'(n_scaled[NW-1:QW]);

  // per-stage partial remainder, pending dividend bits and quotient
  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] dm   [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic          neg  [0:QW];
  logic          ovf  [0:QW];

  // prep: quotient of 2^32 or more always saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= n_top;
      dm[0]  <= den_mag;
      low[0] <= n_scaled[QW-1:0];
      quo[0] <= '0;
      neg[0] <= num[DW-1] ^ den[DW-1];
      ovf[0] <= (n_top >= den_mag);
    end
  end

  // restoring steps, most significant quotient bit first
  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem[j-1], low[j-1][QW-1]};
    assign ge    = (trial >= {1'b0, dm[j-1]});

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= ge ? DW'(trial - {1'b0, dm[j-1]}) : DW'(trial);
        dm[j]  <= dm[j-1];
        low[j] <= {low[j-1][QW-2:0], 1'b0};
        quo[j] <= {quo[j-1][QW-2:0], ge};
        neg[j] <= neg[j-1];
        ovf[j] <= ovf[j-1];
      end
    end
  end

  // sign and saturate
  always_ff @(posedge clk) begin
    if (en[QW+1]) begin
      if (!neg[QW]) begin
        t <= (ovf[QW] || quo[QW][QW-1]) ? rbs_pkg::T_MAX : $signed(quo[QW]);
      end else begin
        t <= (ovf[QW] || (quo[QW][QW-1] && (|quo[QW][QW-2:0]))) ?
             rbs_pkg::T_MIN : -$signed(quo[QW]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ray_box_slab_intersect_2d.sv -----
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_2d
// Segment versus axis-aligned box slab test in signed Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   request carries a box (lower and upper corner) and a segment (start and
//   end point); result returns hit, entry fraction (Q1.16), entry normal and
//   entry point. A miss returns all zeros. Both channels are valid/ready and
//   a request is taken on an edge where valid and ready are both high.
//   A result passes through the input register, the 32 quotient bit stages
//   of the four slab dividers plus prep, saturation, the two slab updates,
//   the multiply and the output register (39 register stages in all).
//   Throughput: one request per cycle; every stage holds its own valid bit.
//   When the receiver stalls the output register holds its result and the
//   stages behind it keep filling bubbles; request.ready drops only once
//   the whole pipeline is full. Nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect_2d #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  rbs_req_if.sink   request,
  rbs_rsp_if.source result
);

  localparam int CW    = rbs_pkg::COORD_W;
  localparam int DW    = rbs_pkg::DELTA_W;
  localparam int TW    = rbs_pkg::T_W;
  localparam int NWD   = rbs_pkg::NORM_W;
  localparam int PW    = DW + TW;
  localparam int S_DIV = rbs_pkg::DIV_LAT;   // last divider stage
  localparam int S_X   = S_DIV + 1;
  localparam int S_Y   = S_DIV + 2;
  localparam int S_MUL = S_DIV + 3;
  localparam int S_OUT = S_DIV + 4;
  localparam int L     = S_OUT + 1;
  localparam int SH_R  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic signed [TW-1:0] ONE_T = TW'(64'sd1 <<< FRAC_BITS);

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 parx;
    logic                 pary;
    logic                 pmiss;
  } side_t;

  // stage valid bits and advance enables
  logic [L-1:0] v;
  logic [L-1:0] en;

  assign en[L-1] = !v[L-1] || result.ready;
  for (genvar k = 0; k < L - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign request.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= request.valid;
      for (int k = 1; k < L; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: slab offsets, deltas and parallel test
  logic signed [DW-1:0] n_lx, n_ux, n_ly, n_uy;
  side_t                side0;
  logic signed [DW-1:0] dx_c, dy_c;

  assign dx_c = DW'(request.end_x) - DW'(request.start_x);
  assign dy_c = DW'(request.end_y) - DW'(request.start_y);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_lx        <= DW'(request.box_lower_x) - DW'(request.start_x);
      n_ux        <= DW'(request.box_upper_x) - DW'(request.start_x);
      n_ly        <= DW'(request.box_lower_y) - DW'(request.start_y);
      n_uy        <= DW'(request.box_upper_y) - DW'(request.start_y);
      side0.sx    <= request.start_x;
      side0.sy    <= request.start_y;
      side0.dx    <= dx_c;
      side0.dy    <= dy_c;
      side0.parx  <= (dx_c == '0);
      side0.pary  <= (dy_c == '0);
      side0.pmiss <=
        ((dx_c == '0) && (request.start_x < request.box_lower_x ||
                          request.box_upper_x < request.start_x)) ||
        ((dy_c == '0) && (request.start_y < request.box_lower_y ||
                          request.box_upper_y < request.start_y));
    end
  end

  // four slab dividers
  logic signed [TW-1:0] t_lx, t_ux, t_ly, t_uy;

  rbs_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_lx (
    .clk(clk), .en(en[S_DIV:1]), .num(n_lx), .den(side0.dx), .t(t_lx)
  );
  rbs_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_ux (
    .clk(clk), .en(en[S_DIV:1]), .num(n_ux), .den(side0.dx), .t(t_ux)
  );
  rbs_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_ly (
    .clk(clk), .en(en[S_DIV:1]), .num(n_ly), .den(side0.dy), .t(t_ly)
  );
  rbs_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_uy (
    .clk(clk), .en(en[S_DIV:1]), .num(n_uy), .den(side0.dy), .t(t_uy)
  );

  // sideband travels alongside the dividers
  side_t side [1:S_DIV];

  always_ff @(posedge clk) begin
    if (en[1]) side[1] <= side0;
    for (int k = 2; k <= S_DIV; k++) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // x slab
  logic                  xs_swap;
  logic signed [TW-1:0]  xs_t1, xs_t2;
  logic signed [TW-1:0]  x_tmin, x_tmax, x_tly, x_tuy;
  logic signed [NWD-1:0] x_nx;
  logic                  x_miss, x_pary;
  logic signed [CW-1:0]  x_sx, x_sy;
  logic signed [DW-1:0]  x_dx, x_dy;

  assign xs_swap = t_lx > t_ux;
  assign xs_t1   = xs_swap ? t_ux : t_lx;
  assign xs_t2   = xs_swap ? t_lx : t_ux;

  always_ff @(posedge clk) begin
    if (en[S_X]) begin
      if (side[S_DIV].parx) begin
        x_tmin <= rbs_pkg::T_MIN;
        x_tmax <= rbs_pkg::T_MAX;
        x_nx   <= rbs_pkg::NORM_ZERO;
      end else begin
        x_tmin <= xs_t1;
        x_tmax <= xs_t2;
        if (xs_t1 > rbs_pkg::T_MIN) begin
          x_nx <= xs_swap ? rbs_pkg::NORM_POS : rbs_pkg::NORM_NEG;
        end else begin
          x_nx <= rbs_pkg::NORM_ZERO;
        end
      end
      x_miss <= side[S_DIV].pmiss;
      x_pary <= side[S_DIV].pary;
      x_tly  <= t_ly;
      x_tuy  <= t_uy;
      x_sx   <= side[S_DIV].sx;
      x_sy   <= side[S_DIV].sy;
      x_dx   <= side[S_DIV].dx;
      x_dy   <= side[S_DIV].dy;
    end
  end

  // y slab
  logic                  ys_swap, ys_enter;
  logic signed [TW-1:0]  ys_t1, ys_t2, ys_tmin, ys_tmax;
  logic signed [TW-1:0]  y_tmin;
  logic signed [NWD-1:0] y_nx, y_ny;
  logic                  y_miss;
  logic signed [CW-1:0]  y_sx, y_sy;
  logic signed [DW-1:0]  y_dx, y_dy;

  assign ys_swap  = x_tly > x_tuy;
  assign ys_t1    = ys_swap ? x_tuy : x_tly;
  assign ys_t2    = ys_swap ? x_tly : x_tuy;
  assign ys_enter = !x_pary && (ys_t1 > x_tmin);
  assign ys_tmin  = ys_enter ? ys_t1 : x_tmin;
  assign ys_tmax  = (!x_pary && (ys_t2 < x_tmax)) ? ys_t2 : x_tmax;

  always_ff @(posedge clk) begin
    if (en[S_Y]) begin
      y_tmin <= ys_tmin;
      if (ys_enter) begin
        y_nx <= rbs_pkg::NORM_ZERO;
        y_ny <= ys_swap ? rbs_pkg::NORM_POS : rbs_pkg::NORM_NEG;
      end else begin
        y_nx <= x_nx;
        y_ny <= rbs_pkg::NORM_ZERO;
      end
      y_miss <= x_miss || (ys_tmin > ys_tmax);
      y_sx   <= x_sx;
      y_sy   <= x_sy;
      y_dx   <= x_dx;
      y_dy   <= x_dy;
    end
  end

  // range check and point products
  logic signed [PW-1:0]  m_px, m_py;
  logic signed [TW-1:0]  m_tmin;
  logic signed [NWD-1:0] m_nx, m_ny;
  logic                  m_miss;
  logic signed [CW-1:0]  m_sx, m_sy;

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      m_px   <= PW'(y_dx) * PW'(y_tmin);
      m_py   <= PW'(y_dy) * PW'(y_tmin);
      m_tmin <= y_tmin;
      m_nx   <= y_nx;
      m_ny   <= y_ny;
      m_miss <= y_miss || (y_tmin < 0) || (y_tmin > ONE_T);
      m_sx   <= y_sx;
      m_sy   <= y_sy;
    end
  end

  // output register
  logic [CW+16-1:0]       frac_wide;
  logic                   o_hit;
  logic [rbs_pkg::FRAC_W-1:0] o_frac;
  logic signed [NWD-1:0]  o_nx, o_ny;
  logic signed [CW-1:0]   o_px, o_py;

  assign frac_wide = ((CW + 16)'(unsigned'(m_tmin)) >> SH_R) << SH_L;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      if (m_miss) begin
        o_hit  <= 1'b0;
        o_frac <= '0;
        o_nx   <= rbs_pkg::NORM_ZERO;
        o_ny   <= rbs_pkg::NORM_ZERO;
        o_px   <= '0;
        o_py   <= '0;
      end else begin
        o_hit  <= 1'b1;
        o_frac <= frac_wide[rbs_pkg::FRAC_W-1:0];
        o_nx   <= m_nx;
        o_ny   <= m_ny;
        o_px   <= m_sx + CW'(m_px >>> FRAC_BITS);
        o_py   <= m_sy + CW'(m_py >>> FRAC_BITS);
      end
    end
  end

  assign result.valid    = v[L-1];
  assign result.hit      = o_hit;
  assign result.fraction = o_frac;
  assign result.normal_x = o_nx;
  assign result.normal_y = o_ny;
  assign result.point_x  = o_px;
  assign result.point_y  = o_py;

  // a miss carries nothing but zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.hit) |->
      (result.fraction == '0 && result.normal_x == rbs_pkg::NORM_ZERO &&
       result.normal_y == rbs_pkg::NORM_ZERO && result.point_x == '0 &&
       result.point_y == '0))
    else $error("miss result with nonzero payload");

  // a hit enters through exactly one face at most and within the segment
  a_hit_shape: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.hit) |->
      (result.fraction <= 17'h10000 &&
       !(result.normal_x != rbs_pkg::NORM_ZERO &&
         result.normal_y != rbs_pkg::NORM_ZERO)))
    else $error("hit with bad fraction or normal");

  // an empty first stage always takes a request
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> request.ready)
    else $error("request stalled with free input stage");

  // a stalled output leaves the stage behind it free to advance only if empty
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v[L-1] && !result.ready && v[L-2]) |-> !en[L-2])
    else $error("pipeline advanced into a stalled output");

endmodule

`default_nettype wire

// ----- bench/tb_ray_box_slab_intersect_2d.sv -----
// ---------------------------------------------------------------------------
// tb_ray_box_slab_intersect_2d
// Feeds box/segment requests, predicts each slab test result in a local
// model and checks every result field in order, with random gaps and stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect_2d;

  localparam int FB = 16;
  localparam int LAT = 39;

  typedef struct packed {
    logic signed [31:0] lx, ly, ux, uy, sx, sy, ex, ey;
  } seg_req_t;

  typedef struct packed {
    logic hit;
    logic [rbs_pkg::FRAC_W-1:0] fraction;
    logic signed [rbs_pkg::NORM_W-1:0] nx, ny;
    logic signed [31:0] px, py;
  } hit_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rbs_req_if request ();
  rbs_rsp_if result ();

  ray_box_slab_intersect_2d #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst), .request(request.sink), .result(result.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hit_rsp_t expected_hits[$];
  int errors = 0;
  int stall_req = 0;   // bumped by a test to start a long receiver hold
  int stall_ack = 0;
  int stall_hold = 0;

  function automatic longint sat_t(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic longint floor_div(longint x);
    if (x >= 0) return x >>> FB;
    return -((-x + ((64'sd1 <<< FB) - 1)) >>> FB);
  endfunction

  // one slab: narrows tmin/tmax, returns 0 on a miss
  function automatic bit slab_narrow(longint lo, longint hi, longint p, longint e,
                                     inout longint tmin, inout longint tmax,
                                     output int sgn, output bit entered);
    longint d, t1, t2, k;
    d = e - p;
    sgn = -1;
    entered = 0;
    if (d == 0) return !(p < lo || hi < p);
    t1 = sat_t(((lo - p) * (64'sd1 <<< FB)) / d);
    t2 = sat_t(((hi - p) * (64'sd1 <<< FB)) / d);
    if (t1 > t2) begin
      k = t1; t1 = t2; t2 = k; sgn = 1;
    end
    if (t1 > tmin) begin
      tmin = t1;
      entered = 1;
    end
    if (t2 < tmax) tmax = t2;
    return !(tmin > tmax);
  endfunction

  function automatic hit_rsp_t predict_hit(seg_req_t r);
    hit_rsp_t o;
    longint tmin, tmax, f;
    int sgn, nx, ny;
    bit ent;
    o = '0;
    tmin = -64'sd2147483648;
    tmax = 64'sd2147483647;
    nx = 0;
    ny = 0;
    if (!slab_narrow(r.lx, r.ux, r.sx, r.ex, tmin, tmax, sgn, ent)) return o;
    if (ent) begin
      nx = sgn; ny = 0;
    end
    if (!slab_narrow(r.ly, r.uy, r.sy, r.ey, tmin, tmax, sgn, ent)) return o;
    if (ent) begin
      nx = 0; ny = sgn;
    end
    if (tmin < 0 || tmin > (64'sd1 <<< FB)) return o;
    f = (FB >= 16) ? (tmin >>> (FB - 16)) : (tmin <<< (16 - FB));
    o.hit = 1'b1;
    o.fraction = f[rbs_pkg::FRAC_W-1:0];
    o.nx = nx[rbs_pkg::NORM_W-1:0];
    o.ny = ny[rbs_pkg::NORM_W-1:0];
    o.px = 32'(longint'(r.sx) + floor_div((longint'(r.ex) - r.sx) * tmin));
    o.py = 32'(longint'(r.sy) + floor_div((longint'(r.ey) - r.sy) * tmin));
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one request, then an optional random gap
  task automatic send_request(seg_req_t r, bit allow_gap = 1);
    int g;
    request.valid <= 1'b1;
    request.box_lower_x <= r.lx;
    request.box_lower_y <= r.ly;
    request.box_upper_x <= r.ux;
    request.box_upper_y <= r.uy;
    request.start_x <= r.sx;
    request.start_y <= r.sy;
    request.end_x <= r.ex;
    request.end_y <= r.ey;
    do @(posedge clk); while (!request.ready);
    expected_hits.push_back(predict_hit(r));
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      request.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic idle_request();
    request.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      stall_hold <= 149;
      result.ready <= 1'b0;
    end else if (stall_hold > 0) begin
      result.ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else result.ready <= ($urandom_range(0, 99) < 70);
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    hit_rsp_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (result.hit !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, result.hit); errors++;
        end
        if (result.fraction !== e.fraction) begin
          $error("fraction exp %0d got %0d", e.fraction, result.fraction); errors++;
        end
        if (result.normal_x !== e.nx) begin
          $error("normal_x exp %0d got %0d", e.nx, result.normal_x); errors++;
        end
        if (result.normal_y !== e.ny) begin
          $error("normal_y exp %0d got %0d", e.ny, result.normal_y); errors++;
        end
        if (result.point_x !== e.px) begin
          $error("point_x exp %0d got %0d", e.px, result.point_x); errors++;
        end
        if (result.point_y !== e.py) begin
          $error("point_y exp %0d got %0d", e.py, result.point_y); errors++;
        end
      end
    end
  end

  function automatic seg_req_t mk(int lx, int ly, int ux, int uy,
                                  int sx, int sy, int ex, int ey);
    seg_req_t r;
    r.lx = lx; r.ly = ly; r.ux = ux; r.uy = uy;
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
    return r;
  endfunction

  function automatic int rand_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
    if (k < 8) return $signed($urandom());
    return k == 8 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // random well-formed box with a random segment, or noise
  function automatic seg_req_t rand_request();
    seg_req_t r;
    int a, b;
    if ($urandom_range(0, 9) < 7) begin
      a = rand_coord(); b = rand_coord();
      r.lx = (a < b) ? a : b; r.ux = (a < b) ? b : a;
      a = rand_coord(); b = rand_coord();
      r.ly = (a < b) ? a : b; r.uy = (a < b) ? b : a;
      r.sx = rand_coord(); r.sy = rand_coord();
      r.ex = rand_coord(); r.ey = rand_coord();
      if ($urandom_range(0, 7) == 0) r.ex = r.sx;
      if ($urandom_range(0, 7) == 0) r.ey = r.sy;
    end else r = {$urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), $urandom()};
    return r;
  endfunction

  task automatic wait_drained();
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    localparam int ONE = 32'sh0001_0000;
    seg_req_t list[$];
    list.push_back(mk(0, 0, ONE, ONE, -ONE, ONE / 2, 2 * ONE, ONE / 2));  // enter -x face
    list.push_back(mk(0, 0, ONE, ONE, 2 * ONE, ONE / 2, -ONE, ONE / 2));  // enter +x face
    list.push_back(mk(0, 0, ONE, ONE, ONE / 2, -ONE, ONE / 2, 2 * ONE));  // -y face, parallel x
    list.push_back(mk(0, 0, ONE, ONE, ONE / 2, 2 * ONE, ONE / 2, -ONE));  // +y face
    list.push_back(mk(0, 0, ONE, ONE, 2 * ONE, -ONE, 2 * ONE, 3 * ONE));  // parallel outside
    list.push_back(mk(0, 0, ONE, ONE, ONE / 2, ONE / 2, 3 * ONE, 3 * ONE)); // start inside
    list.push_back(mk(0, 0, ONE, ONE, ONE / 2, ONE / 2, ONE / 2, ONE / 2)); // both parallel
    list.push_back(mk(0, 0, ONE, ONE, -3 * ONE, ONE / 2, -2 * ONE, ONE / 2)); // beyond end
    list.push_back(mk(0, 0, ONE, ONE, -ONE, ONE / 2, 0, ONE / 2));        // entry at exactly 1
    list.push_back(mk(0, 0, ONE, ONE, 0, ONE / 2, ONE, ONE / 2));          // entry at 0
    list.push_back(mk(ONE, ONE, 0, 0, -ONE, ONE / 2, 2 * ONE, ONE / 2));  // inverted box
    list.push_back(mk(0, 0, ONE, ONE, -ONE, -ONE, 2 * ONE, 2 * ONE));     // corner diagonal
    list.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0));
    list.push_back(mk(-5, -5, 5, 5, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    list.push_back(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
    list.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    list.push_back(mk(0, 0, 1, 1, -1, 0, 32'sh7FFF_FFFF, 0));             // fraction truncates to 0
    foreach (list[i]) send_request(list[i]);
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_request());
  endtask

  // receiver holds off while requests keep coming, so the pipeline backs up
  task automatic test_backpressure();
    idle_request();
    stall_req = stall_req + 1;
    repeat (80) send_request(rand_request(), 0);
  endtask

  // sender pauses until every result has come back
  task automatic test_drain_pause();
    idle_request();
    wait_drained();
    test_random(20);
  endtask

  initial begin
    request.valid <= 1'b0;
    {request.box_lower_x, request.box_lower_y, request.box_upper_x,
     request.box_upper_y, request.start_x, request.start_y,
     request.end_x, request.end_y} <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(150);
    test_backpressure();
    test_drain_pause();
    test_random(150);
    idle_request();
    wait_drained();
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- ray_box_slab_intersect_2d.f -----
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_req_if.sv
hw/rtl/rbs_rsp_if.sv
hw/rtl/rbs_slab_div.sv
hw/rtl/ray_box_slab_intersect_2d.sv
bench/tb_ray_box_slab_intersect_2d.sv
